[rtl/fmacl_pkg.sv]
// ----------------------------------------------------------------------------
// fmacl_pkg - shared types for the first-match access-list classifier
// Transaction structs, entry storage layout, the token that runs down the
// cell chain, and the codes for match kinds, key rules and verdicts.
// ----------------------------------------------------------------------------
package fmacl_pkg;

  // Default table depth
  localparam int ACL_ENTRIES_DEF = 16;

  // Width of the entries_in_use register
  localparam int CNT_W = 5;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RK_SINGLE = 2'd0,
    RK_MASK   = 2'd1,
    RK_SUBNET = 2'd2,
    RK_RANGE  = 2'd3
  } range_kind_t;

  typedef enum logic [1:0] {
    KR_KEY     = 2'd0,
    KR_NOKEY   = 2'd1,
    KR_BLOCKED = 2'd2,
    KR_UNCONF  = 2'd3
  } key_rule_t;

  // Signature state of a query
  localparam logic [1:0] SIG_ABSENT = 2'd0;
  localparam logic [1:0] SIG_OK     = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_ALLOW   = 2'd0,
    VERDICT_NOMATCH = 2'd1,
    VERDICT_BLOCKED = 2'd2,
    VERDICT_WRITTEN = 2'd3
  } verdict_t;

  // Input transaction
  typedef struct packed {
    logic        operation;
    logic [3:0]  entry_index;
    logic        family_v6;
    logic [15:0] port_number;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [63:0] bound_high;
    logic [63:0] bound_low;
    logic [1:0]  range_kind;
    logic [1:0]  key_status;
    logic [7:0]  key_id;
    logic [3:0]  algorithm_id;
  } in_t;

  // Result transaction
  typedef struct packed {
    verdict_t    verdict;
    logic [3:0]  matched_index;
    logic        has_match;
  } out_t;

  // One stored access-list entry
  typedef struct packed {
    logic        family_v6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] bound_high;
    logic [63:0] bound_low;
    range_kind_t kind;
    key_rule_t   rule;
    logic [7:0]  key_id;
    logic [3:0]  algorithm_id;
  } entry_t;

  // Entry write broadcast to every cell
  typedef struct packed {
    logic       en;
    logic [3:0] index;
    entry_t     entry;
  } entry_wr_t;

  // Query token handed from cell to cell with the running verdict
  typedef struct packed {
    logic        valid;
    logic        family_v6;
    logic [15:0] port_number;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [1:0]  key_status;
    logic [7:0]  key_id;
    logic [3:0]  algorithm_id;
    logic        found;
    logic        blocked;
    logic [3:0]  match_index;
  } tok_t;

endpackage

[rtl/first_match_access_list_classifier_top.sv]
// ----------------------------------------------------------------------------
// first_match_access_list_classifier_top - first-match access-list check
// A chain of cells, one entry each; a query token walks the chain one cell
// a cycle and collects the first match or the first blocked match.
// ----------------------------------------------------------------------------
// Write: result strobe one cycle after start; busy stays low.
// Query: result strobe after the launch register, the cell chain (one cell per
//   cycle) and the result register; busy holds until the token leaves the chain,
//   so the next start is taken in the strobe cycle.
// Reset (rst_n low, synchronous) clears busy, strobe, tokens and
//   entries_in_use; table contents are undefined until written.
// Results are driven for one cycle; the receiver cannot stall.
module first_match_access_list_classifier_top #(
  parameter int ACL_ENTRIES = fmacl_pkg::ACL_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  fmacl_pkg::in_t              in_data,
  output logic                        out_strobe,
  output fmacl_pkg::out_t             out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fmacl_pkg::CNT_W-1:0] cfg_data
);

  logic [fmacl_pkg::CNT_W-1:0] entries_in_use_r;
  logic                        busy_r;
  logic                        out_strobe_r;
  fmacl_pkg::out_t             out_r;
  fmacl_pkg::entry_wr_t        wr;
  fmacl_pkg::tok_t             tok [ACL_ENTRIES+1];
  fmacl_pkg::tok_t             tok0_r;
  fmacl_pkg::tok_t             tok0_nxt;
  logic                        accept;
  logic                        is_write;
  logic                        is_query;
  fmacl_pkg::tok_t             tok_end;

  assign accept   = start && !busy_r;
  assign is_write = accept && (in_data.operation == fmacl_pkg::OP_WRITE);
  assign is_query = accept && (in_data.operation == fmacl_pkg::OP_QUERY);
  assign tok_end  = tok[ACL_ENTRIES];

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use_r <= cfg_data;
    end
  end

  // Broadcast entry writes to the chain
  always_comb begin
    wr.en                 = is_write;
    wr.index              = in_data.entry_index;
    wr.entry.family_v6    = in_data.family_v6;
    wr.entry.port         = in_data.port_number;
    wr.entry.addr_high    = in_data.address_high;
    wr.entry.addr_low     = in_data.address_low;
    wr.entry.bound_high   = in_data.bound_high;
    wr.entry.bound_low    = in_data.bound_low;
    wr.entry.kind         = fmacl_pkg::range_kind_t'(in_data.range_kind);
    wr.entry.rule         = fmacl_pkg::key_rule_t'(in_data.key_status);
    wr.entry.key_id       = in_data.key_id;
    wr.entry.algorithm_id = in_data.algorithm_id;
  end

  // Launch a query token into the first cell
  always_comb begin
    tok0_nxt.valid        = is_query;
    tok0_nxt.family_v6    = in_data.family_v6;
    tok0_nxt.port_number  = in_data.port_number;
    tok0_nxt.address_high = in_data.address_high;
    tok0_nxt.address_low  = in_data.address_low;
    tok0_nxt.key_status   = in_data.key_status;
    tok0_nxt.key_id       = in_data.key_id;
    tok0_nxt.algorithm_id = in_data.algorithm_id;
    tok0_nxt.found        = 1'b0;
    tok0_nxt.blocked      = 1'b0;
    tok0_nxt.match_index  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.valid <= 1'b0;
    end else begin
      tok0_r <= tok0_nxt;
    end
  end

  assign tok[0] = tok0_r;

  // Cell chain
  for (genvar i = 0; i < ACL_ENTRIES; i++) begin : g_cell
    fmacl_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .wr             (wr),
      .entries_in_use (entries_in_use_r),
      .tok_in         (tok[i]),
      .tok_out        (tok[i+1])
    );
  end

  // Hold busy from query launch until the token leaves the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (is_query) begin
      busy_r <= 1'b1;
    end else if (tok_end.valid) begin
      busy_r <= 1'b0;
    end
  end

  // Result register: write acknowledgement or final query verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= is_write || tok_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (is_write) begin
      out_r.verdict       <= fmacl_pkg::VERDICT_WRITTEN;
      out_r.matched_index <= '0;
      out_r.has_match     <= 1'b0;
    end else if (tok_end.blocked) begin
      out_r.verdict       <= fmacl_pkg::VERDICT_BLOCKED;
      out_r.matched_index <= tok_end.match_index;
      out_r.has_match     <= 1'b1;
    end else if (tok_end.found) begin
      out_r.verdict       <= fmacl_pkg::VERDICT_ALLOW;
      out_r.matched_index <= tok_end.match_index;
      out_r.has_match     <= 1'b1;
    end else begin
      out_r.verdict       <= fmacl_pkg::VERDICT_NOMATCH;
      out_r.matched_index <= '0;
      out_r.has_match     <= 1'b0;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  // A write is acknowledged in the next cycle
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    is_write |=> (out_strobe && out_data.verdict == fmacl_pkg::VERDICT_WRITTEN))
    else $error("write not acknowledged");

  // A launched query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    is_query |=> busy)
    else $error("busy not raised for query");

  // A token leaving the chain gives a result in the next cycle
  a_tok_out: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.valid |=> (out_strobe && out_data.verdict != fmacl_pkg::VERDICT_WRITTEN))
    else $error("query result lost");

  // Tokens never reach the chain end while idle
  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.valid |-> busy_r)
    else $error("token outside a busy window");

endmodule

[rtl/fmacl_cell.sv]
// ----------------------------------------------------------------------------
// fmacl_cell - one access-list entry and its match stage
// Holds one entry, checks the passing query token against it and hands the
// updated token to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module fmacl_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fmacl_pkg::entry_wr_t        wr,
  input  logic [fmacl_pkg::CNT_W-1:0] entries_in_use,
  input  fmacl_pkg::tok_t             tok_in,
  output fmacl_pkg::tok_t             tok_out
);

  fmacl_pkg::entry_t entry_r;
  fmacl_pkg::tok_t   tok_r;
  fmacl_pkg::tok_t   tok_nxt;

  logic [63:0] ah, al, bh, bl, xh, xl;
  logic        active;
  logic        addr_hit;
  logic        key_hit;
  logic        hit;
  logic        lo_le_x;
  logic        x_le_hi;

  // Capture the entry when the write names this cell
  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.index) == CELL_INDEX)) begin
      entry_r <= wr.entry;
    end
  end

  // Only cells below the in-use count take part
  assign active = (CELL_INDEX < int'(entries_in_use));

  // Narrow to 32 bits for IPv4
  always_comb begin
    ah = entry_r.addr_high;
    al = entry_r.addr_low;
    bh = entry_r.bound_high;
    bl = entry_r.bound_low;
    xh = tok_in.address_high;
    xl = tok_in.address_low;
    if (!tok_in.family_v6) begin
      ah = '0;
      bh = '0;
      xh = '0;
      al = {32'd0, al[31:0]};
      bl = {32'd0, bl[31:0]};
      xl = {32'd0, xl[31:0]};
    end
  end

  // Inclusive range bounds as 128-bit big-endian numbers
  assign lo_le_x = ({ah, al} <= {xh, xl});
  assign x_le_hi = ({xh, xl} <= {bh, bl});

  // Address test by match kind
  always_comb begin
    unique case (entry_r.kind)
      fmacl_pkg::RK_MASK,
      fmacl_pkg::RK_SUBNET: addr_hit = ((ah & bh) == (xh & bh)) && ((al & bl) == (xl & bl));
      fmacl_pkg::RK_RANGE:  addr_hit = lo_le_x && x_le_hi;
      default:              addr_hit = (ah == xh) && (al == xl);
    endcase
  end

  // Key rule against the query signature
  always_comb begin
    unique case (entry_r.rule)
      fmacl_pkg::KR_BLOCKED: key_hit = 1'b1;
      fmacl_pkg::KR_NOKEY:   key_hit = (tok_in.key_status == fmacl_pkg::SIG_ABSENT);
      fmacl_pkg::KR_UNCONF:  key_hit = 1'b0;
      default:               key_hit = (tok_in.key_status == fmacl_pkg::SIG_OK) &&
                                       (entry_r.key_id == tok_in.key_id) &&
                                       (entry_r.algorithm_id == tok_in.algorithm_id);
    endcase
  end

  assign hit = active &&
               (entry_r.family_v6 == tok_in.family_v6) &&
               ((entry_r.port == 16'd0) || (entry_r.port == tok_in.port_number)) &&
               addr_hit && key_hit;

  // Update the running verdict; a blocked match freezes it
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && hit && !tok_in.blocked) begin
      if (entry_r.rule == fmacl_pkg::KR_BLOCKED) begin
        tok_nxt.found       = 1'b1;
        tok_nxt.blocked     = 1'b1;
        tok_nxt.match_index = 4'(CELL_INDEX);
      end else if (!tok_in.found) begin
        tok_nxt.found       = 1'b1;
        tok_nxt.match_index = 4'(CELL_INDEX);
      end
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - first-match access-list classifier
// Writes table entries and checks queries against them. A directed table
// covers every match kind, every key rule, port wildcards, IPv4 masking,
// blocked overrides and count saturation. A random mix follows: mostly
// queries built to hit a live entry, plus noise and fresh entry writes.
// Each result is checked against its directed expectation or an in-bench classifier model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fmacl_pkg::*;

  localparam int ACL_ENTRIES  = ACL_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1030;
  localparam int PHASE_ITEMS  = 150;
  localparam int STALL_LIMIT  = 2000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_data;
  logic             out_strobe;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  // Classifier model state
  entry_t           acl_table [ACL_ENTRIES];
  logic [CNT_W-1:0] live_count;
  out_t             pending_verdicts [$];

  int  fail_count;
  int  reported;
  int  stall_cycles;
  bit  burst;

  typedef struct {
    bit               set_count;
    logic [CNT_W-1:0] count;
    in_t              item;
    bit               typed;
    out_t             result;
  } dir_row_t;

  dir_row_t directed_rows [$];

  first_match_access_list_classifier_top #(
    .ACL_ENTRIES(ACL_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic out_t outcome(verdict_t v, logic [3:0] idx, logic hit);
    out_t r;
    r.verdict       = v;
    r.matched_index = idx;
    r.has_match     = hit;
    return r;
  endfunction

  function automatic in_t mk(op_t op, logic [3:0] idx, logic v6, logic [15:0] port,
                             logic [127:0] addr, logic [127:0] bound, range_kind_t kind,
                             logic [1:0] status, logic [7:0] kid, logic [3:0] alg);
    in_t t;
    t.operation    = op;
    t.entry_index  = idx;
    t.family_v6    = v6;
    t.port_number  = port;
    t.address_high = addr[127:64];
    t.address_low  = addr[63:0];
    t.bound_high   = bound[127:64];
    t.bound_low    = bound[63:0];
    t.range_kind   = kind;
    t.key_status   = status;
    t.key_id       = kid;
    t.algorithm_id = alg;
    return t;
  endfunction

  // Address test for one entry; IPv4 compares the low 32 bits only
  function automatic bit address_hits(entry_t e, in_t q);
    logic [127:0] a, b, x;
    a = {e.addr_high, e.addr_low};
    b = {e.bound_high, e.bound_low};
    x = {q.address_high, q.address_low};
    if (!q.family_v6) begin
      a[127:32] = '0;
      b[127:32] = '0;
      x[127:32] = '0;
    end
    case (e.kind)
      RK_MASK, RK_SUBNET: return (a & b) == (x & b);
      RK_RANGE:           return (a <= x) && (x <= b);
      default:            return a == x;
    endcase
  endfunction

  function automatic bit key_accepts(entry_t e, in_t q);
    case (e.rule)
      KR_BLOCKED: return 1'b1;
      KR_NOKEY:   return q.key_status == SIG_ABSENT;
      KR_UNCONF:  return 1'b0;
      default:    return q.key_status == SIG_OK && e.key_id == q.key_id &&
                         e.algorithm_id == q.algorithm_id;
    endcase
  endfunction

  // Apply one accepted transaction to the model and return its verdict
  function automatic out_t classify(in_t q);
    entry_t e;
    int     n;
    bit     found;
    int     first;
    found = 1'b0;
    first = 0;
    if (q.operation == OP_WRITE) begin
      e.family_v6    = q.family_v6;
      e.port         = q.port_number;
      e.addr_high    = q.address_high;
      e.addr_low     = q.address_low;
      e.bound_high   = q.bound_high;
      e.bound_low    = q.bound_low;
      e.kind         = range_kind_t'(q.range_kind);
      e.rule         = key_rule_t'(q.key_status);
      e.key_id       = q.key_id;
      e.algorithm_id = q.algorithm_id;
      if (q.entry_index < ACL_ENTRIES) acl_table[q.entry_index] = e;
      return outcome(VERDICT_WRITTEN, 4'd0, 1'b0);
    end
    // Saturate the count, then scan in order; a blocked hit ends the scan
    n = (live_count > ACL_ENTRIES) ? ACL_ENTRIES : live_count;
    for (int i = 0; i < n; i++) begin
      e = acl_table[i];
      if (e.family_v6 != q.family_v6) continue;
      if (e.port != 16'd0 && e.port != q.port_number) continue;
      if (!address_hits(e, q) || !key_accepts(e, q)) continue;
      if (!found) begin
        found = 1'b1;
        first = i;
      end
      if (e.rule == KR_BLOCKED) return outcome(VERDICT_BLOCKED, i[3:0], 1'b1);
    end
    if (found) return outcome(VERDICT_ALLOW, first[3:0], 1'b1);
    return outcome(VERDICT_NOMATCH, 4'd0, 1'b0);
  endfunction

  function automatic in_t random_entry_write();
    logic [127:0] a, b, off;
    logic         v6;
    range_kind_t  kind;
    int           len;
    logic [15:0]  port;
    v6   = 1'($urandom_range(1, 0));
    kind = range_kind_t'($urandom_range(3, 0));
    a    = rand128();
    b    = rand128();
    if (!v6 && $urandom_range(1, 0)) a[127:32] = '0;
    case (kind)
      RK_MASK, RK_SUBNET: begin
        // Prefix masks most of the time, arbitrary masks otherwise
        if ($urandom_range(2, 0) != 0) begin
          if (v6) begin
            len = $urandom_range(128, 0);
            b   = {128{1'b1}} << (128 - len);
          end else begin
            len      = $urandom_range(32, 0);
            b[31:0]  = {32{1'b1}} << (32 - len);
          end
        end
      end
      RK_RANGE: begin
        off = $urandom_range(1, 0) ? 128'($urandom_range(1000, 0))
                                   : rand128() >> $urandom_range(127, 0);
        if ($urandom_range(7, 0) != 0) b = a + off;
      end
      default: ;
    endcase
    case ($urandom_range(3, 0))
      0, 1:    port = 16'd0;
      2:       port = 16'($urandom_range(65535, 0));
      default: port = 16'hFFFF;
    endcase
    return mk(OP_WRITE, 4'($urandom_range(15, 0)), v6, port, a, b, kind,
              2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
              4'($urandom_range(15, 0)));
  endfunction

  // Mostly queries aimed at a live entry, the rest random noise
  function automatic in_t random_query();
    entry_t       e;
    logic [127:0] a, b, x, r, span;
    range_kind_t  rk;
    logic [1:0]   status;
    logic [7:0]   kid;
    logic [3:0]   alg;
    logic [15:0]  port;
    int           n;
    int           bitpos;
    n  = (live_count > ACL_ENTRIES) ? ACL_ENTRIES : live_count;
    rk = range_kind_t'($urandom_range(3, 0));
    if (n == 0 || $urandom_range(3, 0) == 0)
      return mk(OP_QUERY, 4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)),
                16'($urandom_range(65535, 0)), rand128(), rand128(), rk,
                2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                4'($urandom_range(15, 0)));
    e = acl_table[$urandom_range(n - 1, 0)];
    a = {e.addr_high, e.addr_low};
    b = {e.bound_high, e.bound_low};
    r = rand128();
    if (!e.family_v6) begin
      a[127:32] = '0;
      b[127:32] = '0;
    end
    case (e.kind)
      RK_MASK, RK_SUBNET: x = (a & b) | (r & ~b);
      RK_RANGE: begin
        if (a <= b) begin
          span = b - a;
          case ($urandom_range(2, 0))
            0:       x = a;
            1:       x = b;
            default: x = (span == '1) ? r : a + r % (span + 1);
          endcase
        end else begin
          x = r;
        end
      end
      default: x = a;
    endcase
    // IPv4 queries carry junk above bit 31
    if (!e.family_v6) x[127:32] = 96'(rand128());
    if ($urandom_range(9, 0) == 0) begin
      bitpos    = e.family_v6 ? $urandom_range(127, 0) : $urandom_range(31, 0);
      x[bitpos] = ~x[bitpos];
    end
    port = (e.port == 16'd0 || $urandom_range(9, 0) == 0) ? 16'($urandom_range(65535, 0))
                                                           : e.port;
    status = 2'($urandom_range(3, 0));
    kid    = 8'($urandom_range(255, 0));
    alg    = 4'($urandom_range(15, 0));
    if (e.rule == KR_KEY && $urandom_range(9, 0) != 0) begin
      status = SIG_OK;
      kid    = e.key_id;
      alg    = e.algorithm_id;
    end else if (e.rule == KR_NOKEY && $urandom_range(6, 0) != 0) begin
      status = SIG_ABSENT;
    end
    return mk(OP_QUERY, 4'($urandom_range(15, 0)), e.family_v6, port, x, rand128(), rk,
              status, kid, alg);
  endfunction

  // Present one transaction after a random gap; hold start across back-to-back items
  task automatic send(in_t x, bit typed, out_t typed_result);
    int   gap;
    out_t r;
    gap = burst ? 0 : $urandom_range(8, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    r = classify(x);
    pending_verdicts.push_back(typed ? typed_result : r);
  endtask

  // Write the entry count once the block has drained
  task automatic set_count(logic [CNT_W-1:0] v);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    live_count  = v;
  endtask

  task automatic add_row(bit setc, logic [CNT_W-1:0] c, in_t x, bit typed, out_t r);
    dir_row_t row;
    row.set_count = setc;
    row.count     = c;
    row.item      = x;
    row.typed     = typed;
    row.result    = r;
    directed_rows.push_back(row);
  endtask

  // Check each result against the oldest expectation; watch for a hang
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (out_strobe) begin
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result: verdict %0d index %0d match %0d",
                     out_data.verdict, out_data.matched_index, out_data.has_match);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (want.verdict !== out_data.verdict ||
              want.matched_index !== out_data.matched_index ||
              want.has_match !== out_data.has_match) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.verdict, want.matched_index, want.has_match,
                       out_data.verdict, out_data.matched_index, out_data.has_match);
            end
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] count_plan [7];
    logic [127:0]     v6_ones;
    in_t              x;
    int               phase;
    count_plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd8, 5'd15, 5'd17};
    v6_ones    = {128{1'b1}};
    fail_count = 0;
    reported   = 0;
    burst      = 1'b0;
    live_count = '0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;

    // Empty list: nothing is checked
    add_row(1'b1, 5'd0, mk(OP_QUERY, 4'd0, 1'b0, 16'd80, 128'h0A000001, '0, RK_SINGLE,
            SIG_ABSENT, 8'd0, 4'd0), 1'b1, outcome(VERDICT_NOMATCH, 4'd0, 1'b0));
    // Fill the whole table: each match kind and key rule, both families
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd0, 1'b0, 16'd0,
            {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_C0A8_0001}, v6_ones, RK_SINGLE,
            KR_NOKEY, 8'd0, 4'd0), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd1, 1'b0, 16'd53, 128'h0A000000, 128'hFF000000,
            RK_MASK, KR_KEY, 8'hFF, 4'hF), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd2, 1'b0, 16'hFFFF, 128'h0A000000, 128'hFFFF0000,
            RK_SUBNET, KR_BLOCKED, 8'd0, 4'd0), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd3, 1'b0, 16'd0, '0, 128'hFFFFFFFF, RK_RANGE,
            KR_UNCONF, 8'h12, 4'h3), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd4, 1'b1, 16'd0, v6_ones, '0, RK_SINGLE, KR_KEY,
            8'd0, 4'd0), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd5, 1'b1, 16'd1, {32'h20010DB8, 96'h0},
            {32'hFFFFFFFF, 96'h0}, RK_MASK, KR_NOKEY, 8'd0, 4'd0), 1'b1,
            outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd6, 1'b1, 16'd0, '0, v6_ones, RK_RANGE, KR_BLOCKED,
            8'd0, 4'd0), 1'b1, outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_WRITE, 4'd7, 1'b1, 16'd0, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF},
            {64'd1, 64'd0}, RK_RANGE, KR_KEY, 8'h5A, 4'hA), 1'b1,
            outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    for (int i = 8; i < ACL_ENTRIES; i++)
      add_row(1'b0, 5'd0, mk(OP_WRITE, i[3:0], 1'b0, 16'(i), 128'(32'h01010100 + i), '0,
              RK_SINGLE, 2'(i % 4), 8'(i), 4'(i)), 1'b1,
              outcome(VERDICT_WRITTEN, 4'd0, 1'b0));
    // IPv4 junk above bit 31 is ignored; entry 0 takes an absent signature
    add_row(1'b1, 5'd16, mk(OP_QUERY, 4'd9, 1'b0, 16'd9,
            {64'h1234, 64'hAAAA_AAAA_C0A8_0001}, '0, RK_SINGLE, SIG_ABSENT, 8'd0, 4'd0),
            1'b1, outcome(VERDICT_ALLOW, 4'd0, 1'b1));
    add_row(1'b0, 5'd0, mk(OP_QUERY, 4'd0, 1'b0, 16'd53, 128'h0A000505, '0, RK_SINGLE,
            SIG_OK, 8'hFF, 4'hF), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    // Blocked subnet on the top port number, bad signature
    add_row(1'b0, 5'd0, mk(OP_QUERY, 4'd0, 1'b0, 16'hFFFF, 128'h0A000505, '0, RK_SINGLE,
            2'd3, 8'd0, 4'd0), 1'b1, outcome(VERDICT_BLOCKED, 4'd2, 1'b1));
    // Key hit on entry 4, overridden by the later blocked range
    add_row(1'b0, 5'd0, mk(OP_QUERY, 4'd0, 1'b1, 16'd7, v6_ones, '0, RK_SINGLE, SIG_OK,
            8'd0, 4'd0), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_QUERY, 4'd0, 1'b1, 16'd1, {32'h20010DB8, 96'h1}, '0,
            RK_SINGLE, SIG_ABSENT, 8'd0, 4'd0), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    // Oversized count saturates to the table depth
    add_row(1'b1, 5'd31, mk(OP_QUERY, 4'd0, 1'b1, 16'd1, {64'd1, 64'd0}, '0, RK_SINGLE,
            2'd2, 8'h5A, 4'hA), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    // Short list: the blocked range is out of reach
    add_row(1'b1, 5'd5, mk(OP_QUERY, 4'd0, 1'b1, 16'd7, v6_ones, '0, RK_SINGLE, SIG_OK,
            8'd0, 4'd0), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    add_row(1'b0, 5'd0, mk(OP_QUERY, 4'd0, 1'b0, 16'd53, 128'h0A010203, '0, RK_SINGLE,
            SIG_OK, 8'hFE, 4'hF), 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_count) set_count(directed_rows[i].count);
      send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    // Random mix, changing the entry count between phases
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        phase = k / PHASE_ITEMS;
        set_count(phase < 7 ? count_plan[phase] : 5'($urandom_range(31, 0)));
      end
      if (k % 40 == 0) burst = ($urandom_range(3, 0) == 0);
      x = ($urandom_range(9, 0) < 3) ? random_entry_write() : random_query();
      send(x, 1'b0, outcome(VERDICT_ALLOW, 4'd0, 1'b0));
    end
    start <= 1'b0;

    // Drain, then let the chain settle
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (ACL_ENTRIES + 4) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
